### sv/rgbfade_pkg.sv
// shared types, codes and helpers for the rgb led fade controller
`timescale 1ns / 1ps

package rgbfade_pkg;

  // request codes carried by req_type
  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_OFF  = 2'd1,
    REQ_SET  = 2'd2,
    REQ_FADE = 2'd3
  } req_t;

  // operating mode reported on mode_now
  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_STEADY = 2'd1,
    MODE_FADE   = 2'd2
  } mode_t;

  // top level sequencer
  typedef enum logic [1:0] {
    T_IDLE = 2'd0,
    T_CALC = 2'd1,
    T_WAIT = 2'd2,
    T_OUT  = 2'd3
  } top_state_t;

  // increment unit sequencer
  typedef enum logic [1:0] {
    U_IDLE = 2'd0,
    U_MUL  = 2'd1,
    U_DIV  = 2'd2,
    U_DONE = 2'd3
  } unit_state_t;

  // configuration register indexes
  localparam logic REG_INVERT      = 1'b0;
  localparam logic REG_TICK_PERIOD = 1'b1;

  localparam logic [7:0] LEVEL_MAX  = 8'd255;
  localparam logic [8:0] PERIOD_MIN = 9'd8;
  localparam logic [8:0] PERIOD_MAX = 9'd300;
  localparam logic [8:0] COUNT_MAX  = 9'd511;

  // clamp a signed request to 0..255, inverted when inv is set for common anode wiring
  function automatic logic [7:0] clamp_level(input logic signed [15:0] v, input logic inv);
    logic [7:0] r;
    if (v < 16'sd0) begin
      r = 8'd0;
    end else if (v > 16'sd255) begin
      r = LEVEL_MAX;
    end else begin
      r = v[7:0];
    end
    if (inv) begin
      r = LEVEL_MAX - r;
    end
    return r;
  endfunction

endpackage

### sv/rgb_led_fade_controller_unit.sv
// top level of the rgb led fade controller
`timescale 1ns / 1ps

// Three-channel LED duty controller. Each input item is a millisecond tick,
// a turn-off, a set-color or a start-fade command; each item gives exactly one
// result item with the three duties, the mode and the fade done flag.
// Channels use valid/stall; an item moves on an edge with valid high and
// stall low. Configuration (level inversion, tick_period_ms) goes in through
// cfg_we/cfg_index/cfg_data; the user must write it only while the block is
// idle, which the block itself does not enforce. Tick, off and set items are
// handled on the accepting edge: the result is registered at that edge, one
// item per cycle while no fade runs and the output is not stalled. A fade
// command runs the shared multiply/divide unit once per channel, a multiply
// and then a one-bit-per-cycle restoring divide, before its result is
// registered; in_stall is high meanwhile.
// When the receiver stalls, the result holds in the output register and the
// input stalls for as long as it is held.
// Reset clears all levels, targets, increments, mode and flag, sets
// tick_period_ms to 20 and clears the inversion flag; no item is pending.

module rgb_led_fade_controller_unit #(
  parameter int FRACTION_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic signed [15:0] red_in,
  input  logic signed [15:0] green_in,
  input  logic signed [15:0] blue_in,
  input  logic [15:0] fade_time_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_duty,
  output logic [7:0]  green_duty,
  output logic [7:0]  blue_duty,
  output logic [1:0]  mode_now,
  output logic        fade_done,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int LW = 8 + FRACTION_BITS;

  rgbfade_pkg::top_state_t state;
  rgbfade_pkg::top_state_t state_next;

  logic                invert_levels;
  logic [8:0]          tick_period_ms;
  rgbfade_pkg::mode_t  mode_reg;
  rgbfade_pkg::mode_t  mode_reg_next;
  logic [8:0]          ms_since_step;
  logic [8:0]          ms_since_step_next;
  logic [LW-1:0]       level [3];
  logic [LW-1:0]       level_next [3];
  logic [7:0]          target [3];
  logic [7:0]          target_next [3];
  logic signed [LW:0]  step_size [3];
  logic signed [LW:0]  step_size_next [3];
  logic                done_flag;
  logic                done_flag_next;
  logic [15:0]         fade_t;
  logic [15:0]         fade_t_next;
  logic [1:0]          ch;
  logic [1:0]          ch_next;

  logic                accept;
  logic                out_full;
  logic                load_out;
  logic                unit_start;
  logic                unit_done;
  logic signed [LW:0]  unit_step;
  logic signed [LW:0]  unit_diff;
  logic [LW-1:0]       lane_out [3];
  logic signed [15:0]  chan_in [3];
  logic [8:0]          cnt_inc;
  logic                all_match;

  assign chan_in[0] = red_in;
  assign chan_in[1] = green_in;
  assign chan_in[2] = blue_in;

  assign out_full = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign unit_diff = $signed({1'b0, target[ch], {FRACTION_BITS{1'b0}}})
                   - $signed({1'b0, level[ch]});

  rgbfade_incr_unit #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_incr (
    .clk     (clk),
    .rst     (rst),
    .start   (unit_start),
    .diff    (unit_diff),
    .period  (tick_period_ms),
    .divisor (fade_t),
    .done    (unit_done),
    .step    (unit_step)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    rgbfade_step_lane #(
      .FRACTION_BITS(FRACTION_BITS)
    ) u_lane (
      .level     (level[i]),
      .step      (step_size[i]),
      .target    (target[i]),
      .level_new (lane_out[i])
    );
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      rgbfade_pkg::T_IDLE: begin
        if (accept && rgbfade_pkg::req_t'(req_type) == rgbfade_pkg::REQ_FADE) begin
          state_next = rgbfade_pkg::T_CALC;
        end
      end
      rgbfade_pkg::T_CALC: state_next = rgbfade_pkg::T_WAIT;
      rgbfade_pkg::T_WAIT: begin
        if (unit_done) begin
          state_next = (ch == 2'd2) ? rgbfade_pkg::T_OUT : rgbfade_pkg::T_CALC;
        end
      end
      rgbfade_pkg::T_OUT: if (!out_full) state_next = rgbfade_pkg::T_IDLE;
      default: state_next = rgbfade_pkg::T_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall   = 1'b1;
    unit_start = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      rgbfade_pkg::T_IDLE: begin
        in_stall = out_full;
        load_out = accept && rgbfade_pkg::req_t'(req_type) != rgbfade_pkg::REQ_FADE;
      end
      rgbfade_pkg::T_CALC: unit_start = 1'b1;
      rgbfade_pkg::T_WAIT: begin
      end
      rgbfade_pkg::T_OUT:  load_out = !out_full;
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    mode_reg_next      = mode_reg;
    ms_since_step_next = ms_since_step;
    done_flag_next     = done_flag;
    fade_t_next        = fade_t;
    ch_next            = ch;
    for (int i = 0; i < 3; i++) begin
      level_next[i]     = level[i];
      target_next[i]    = target[i];
      step_size_next[i] = step_size[i];
    end
    cnt_inc = (ms_since_step < rgbfade_pkg::COUNT_MAX) ? ms_since_step + 9'd1 : ms_since_step;
    all_match = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (level[i] != {target[i], {FRACTION_BITS{1'b0}}}) all_match = 1'b0;
    end

    if (accept) begin
      unique case (rgbfade_pkg::req_t'(req_type))
        rgbfade_pkg::REQ_TICK: begin
          ms_since_step_next = cnt_inc;
          if (mode_reg != rgbfade_pkg::MODE_OFF && cnt_inc > tick_period_ms) begin
            ms_since_step_next = '0;
            if (mode_reg == rgbfade_pkg::MODE_FADE) begin
              if (all_match) begin
                done_flag_next = 1'b1;
              end else begin
                for (int i = 0; i < 3; i++) level_next[i] = lane_out[i];
              end
            end
          end
        end
        rgbfade_pkg::REQ_OFF: begin
          mode_reg_next = rgbfade_pkg::MODE_OFF;
          for (int i = 0; i < 3; i++) begin
            level_next[i] = invert_levels ? {rgbfade_pkg::LEVEL_MAX, {FRACTION_BITS{1'b0}}} : '0;
          end
        end
        rgbfade_pkg::REQ_SET: begin
          mode_reg_next = rgbfade_pkg::MODE_STEADY;
          for (int i = 0; i < 3; i++) begin
            level_next[i] = {rgbfade_pkg::clamp_level(chan_in[i], invert_levels),
                             {FRACTION_BITS{1'b0}}};
          end
        end
        rgbfade_pkg::REQ_FADE: begin
          mode_reg_next  = rgbfade_pkg::MODE_FADE;
          done_flag_next = 1'b0;
          ch_next        = 2'd0;
          fade_t_next    = (fade_time_ms < {7'd0, tick_period_ms}) ? {7'd0, tick_period_ms}
                                                                   : fade_time_ms;
          for (int i = 0; i < 3; i++) begin
            target_next[i] = rgbfade_pkg::clamp_level(chan_in[i], invert_levels);
          end
        end
        default: begin
        end
      endcase
    end

    if (state == rgbfade_pkg::T_WAIT && unit_done) begin
      step_size_next[ch] = unit_step;
      ch_next = (ch == 2'd2) ? 2'd0 : ch + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= rgbfade_pkg::T_IDLE;
      invert_levels  <= 1'b0;
      tick_period_ms <= 9'd20;
      mode_reg       <= rgbfade_pkg::MODE_OFF;
      ms_since_step  <= '0;
      done_flag      <= 1'b0;
      ch             <= '0;
      out_valid      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        level[i]     <= '0;
        target[i]    <= '0;
        step_size[i] <= '0;
      end
    end else begin
      state         <= state_next;
      mode_reg      <= mode_reg_next;
      ms_since_step <= ms_since_step_next;
      done_flag     <= done_flag_next;
      ch            <= ch_next;
      for (int i = 0; i < 3; i++) begin
        level[i]     <= level_next[i];
        target[i]    <= target_next[i];
        step_size[i] <= step_size_next[i];
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          rgbfade_pkg::REG_INVERT: invert_levels <= cfg_data[0];
          rgbfade_pkg::REG_TICK_PERIOD: begin
            if (cfg_data < rgbfade_pkg::PERIOD_MIN) begin
              tick_period_ms <= rgbfade_pkg::PERIOD_MIN;
            end else if (cfg_data > rgbfade_pkg::PERIOD_MAX) begin
              tick_period_ms <= rgbfade_pkg::PERIOD_MAX;
            end else begin
              tick_period_ms <= cfg_data;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result register, taken from the values this item leaves behind
  always_ff @(posedge clk) begin
    fade_t <= fade_t_next;
    if (load_out) begin
      red_duty   <= level_next[0][LW-1:FRACTION_BITS];
      green_duty <= level_next[1][LW-1:FRACTION_BITS];
      blue_duty  <= level_next[2][LW-1:FRACTION_BITS];
      mode_now   <= mode_reg_next;
      fade_done  <= done_flag_next;
    end
  end

  a_fade_starts_unit: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == rgbfade_pkg::REQ_FADE |=> state == rgbfade_pkg::T_CALC)
    else $error("fade command did not start the increment sequence");

  a_unit_done_waited: assert property (@(posedge clk) disable iff (rst)
    unit_done |-> state == rgbfade_pkg::T_WAIT)
    else $error("increment unit finished outside the wait state");

  a_short_item_result: assert property (@(posedge clk) disable iff (rst)
    accept && req_type != rgbfade_pkg::REQ_FADE |=> out_valid)
    else $error("tick or command item gave no result");

  a_period_range: assert property (@(posedge clk) disable iff (rst)
    tick_period_ms >= rgbfade_pkg::PERIOD_MIN && tick_period_ms <= rgbfade_pkg::PERIOD_MAX)
    else $error("tick period left its clamped range");

endmodule

### sv/rgbfade_step_lane.sv
// one channel of a fade step: add increment, saturate, snap to target
`timescale 1ns / 1ps

module rgbfade_step_lane #(
  parameter int FRACTION_BITS = 12
) (
  input  logic [8+FRACTION_BITS-1:0]        level,
  input  logic signed [8+FRACTION_BITS:0]   step,
  input  logic [7:0]                        target,
  output logic [8+FRACTION_BITS-1:0]        level_new
);

  localparam int LW = 8 + FRACTION_BITS;
  localparam logic signed [LW+1:0] TOP = {2'b00, rgbfade_pkg::LEVEL_MAX, {FRACTION_BITS{1'b0}}};
  localparam logic signed [LW+1:0] ONE = {{(LW+1-FRACTION_BITS){1'b0}}, 1'b1,
                                          {FRACTION_BITS{1'b0}}};

  logic signed [LW+1:0] sum;
  logic signed [LW+1:0] sat;
  logic signed [LW+1:0] tgt;
  logic signed [LW+1:0] gap;
  logic signed [LW+1:0] gap_abs;
  logic signed [LW+1:0] v;

  always_comb begin
    tgt = {2'b00, target, {FRACTION_BITS{1'b0}}};
    sum = $signed({2'b00, level}) + $signed({step[LW], step});
    if (sum < 0) begin
      sat = '0;
    end else if (sum > TOP) begin
      sat = TOP;
    end else begin
      sat = sum;
    end
    gap = sat - tgt;
    gap_abs = gap[LW+1] ? -gap : gap;
    // within one whole level of the target: land on it
    v = (gap_abs < ONE) ? tgt : sat;
    level_new = v[LW-1:0];
  end

endmodule

### sv/rgbfade_incr_unit.sv
// shared increment unit: |diff| * period, then restoring divide by fade time
`timescale 1ns / 1ps

module rgbfade_incr_unit #(
  parameter int FRACTION_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [8+FRACTION_BITS:0]   diff,
  input  logic [8:0]                        period,
  input  logic [15:0]                       divisor,
  output logic                              done,
  output logic signed [8+FRACTION_BITS:0]   step
);

  localparam int LW = 8 + FRACTION_BITS;
  localparam int CW = $clog2(LW);

  rgbfade_pkg::unit_state_t state;
  rgbfade_pkg::unit_state_t state_next;

  logic              neg;
  logic [LW-1:0]     mag;
  logic [15:0]       rem;
  logic [LW-1:0]     quo;
  logic [CW-1:0]     cnt;

  logic signed [LW:0] diff_neg;
  logic [LW+8:0]      prod;
  logic [16:0]        trial;
  logic [16:0]        trial_sub;
  logic               fits;
  logic signed [LW:0] quo_s;

  assign diff_neg  = -diff;
  assign prod      = mag * period;
  assign trial     = {rem, quo[LW-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign fits      = trial >= {1'b0, divisor};
  assign quo_s     = $signed({1'b0, quo});

  always_comb begin
    state_next = state;
    unique case (state)
      rgbfade_pkg::U_IDLE: if (start) state_next = rgbfade_pkg::U_MUL;
      rgbfade_pkg::U_MUL:  state_next = rgbfade_pkg::U_DIV;
      rgbfade_pkg::U_DIV:  if (cnt == CW'(LW - 1)) state_next = rgbfade_pkg::U_DONE;
      rgbfade_pkg::U_DONE: state_next = rgbfade_pkg::U_IDLE;
      default:             state_next = rgbfade_pkg::U_IDLE;
    endcase
  end

  always_comb begin
    done = (state == rgbfade_pkg::U_DONE);
    // truncate toward zero: divide magnitudes, restore sign
    step = neg ? -quo_s : quo_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgbfade_pkg::U_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == rgbfade_pkg::U_DIV) begin
        cnt <= cnt + CW'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rgbfade_pkg::U_IDLE: begin
        if (start) begin
          neg <= diff[LW];
          mag <= diff[LW] ? diff_neg[LW-1:0] : diff[LW-1:0];
        end
      end
      rgbfade_pkg::U_MUL: begin
        // quotient fits LW bits since period <= divisor, so the top part starts below it
        rem <= {7'd0, prod[LW+8:LW]};
        quo <= prod[LW-1:0];
      end
      rgbfade_pkg::U_DIV: begin
        rem <= fits ? trial_sub[15:0] : trial[15:0];
        quo <= {quo[LW-2:0], fits};
      end
      default: begin
      end
    endcase
  end

endmodule
